/* design/fpip_pkg.sv */
// Shared types and a helper function for the incremental PI controller.
package fpip_pkg;

    // Data and register widths.
    localparam int SampleWidth = 12;
    localparam int GainWidth   = 16;
    localparam int AccWidth    = 16;
    localparam int WideWidth   = 17;
    localparam int ProdWidth   = 30;
    localparam int PropShift   = 12;
    localparam int IntegShift  = 16;

    // Register indexes on the configuration port.
    localparam logic [1:0] RegPropGain   = 2'd0;
    localparam logic [1:0] RegIntegGain  = 2'd1;
    localparam logic [1:0] RegLowerLimit = 2'd2;
    localparam logic [1:0] RegUpperLimit = 2'd3;

    // Reset values of the registers.
    localparam logic [GainWidth-1:0]          PropGainReset   = 16'd4096;
    localparam logic [GainWidth-1:0]          IntegGainReset  = 16'd0;
    localparam logic signed [SampleWidth-1:0] LowerLimitReset = -12'sd2048;
    localparam logic [SampleWidth-1:0]        UpperLimitReset = 12'd2048;

    // Controller settings handed from the register block to the datapath.
    typedef struct packed {
        logic [GainWidth-1:0]          prop_gain;
        logic [GainWidth-1:0]          integ_gain;
        logic signed [SampleWidth-1:0] lower_limit;
        logic [SampleWidth-1:0]        upper_limit;
    } cfg_t;

    // Clamp to the limits; the upper limit is tested first, so with crossed limits a value
    // above the upper limit resolves to the upper one and any other value to the lower one.
    function automatic logic signed [WideWidth-1:0] clamp_lim(
        input logic signed [WideWidth-1:0]   v,
        input logic signed [SampleWidth-1:0] lo,
        input logic [SampleWidth-1:0]        hi
    );
        logic signed [WideWidth-1:0] lo_w;
        logic signed [WideWidth-1:0] hi_w;
        logic signed [WideWidth-1:0] res;
        lo_w = {{(WideWidth-SampleWidth){lo[SampleWidth-1]}}, lo};
        hi_w = $signed({{(WideWidth-SampleWidth){1'b0}}, hi});
        if (v > hi_w) begin
            res = hi_w;
        end else if (v < lo_w) begin
            res = lo_w;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

/* design/fpip_cfg.sv */
// Configuration register file with an APB-style access port.
module fpip_cfg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output fpip_pkg::cfg_t     cfg
);

    logic [15:0]        prop_gain_reg;
    logic [15:0]        integ_gain_reg;
    logic signed [11:0] lower_limit_reg;
    logic [11:0]        upper_limit_reg;
    logic               wr_en;
    logic [1:0]         reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg   <= fpip_pkg::PropGainReset;
            integ_gain_reg  <= fpip_pkg::IntegGainReset;
            lower_limit_reg <= fpip_pkg::LowerLimitReset;
            upper_limit_reg <= fpip_pkg::UpperLimitReset;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                fpip_pkg::RegPropGain:   prop_gain_reg   <= pwdata[15:0];
                fpip_pkg::RegIntegGain:  integ_gain_reg  <= pwdata[15:0];
                fpip_pkg::RegLowerLimit: lower_limit_reg <= $signed(pwdata[11:0]);
                fpip_pkg::RegUpperLimit: upper_limit_reg <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    // Register reads; the lower limit reads back sign extended.
    always_comb
    begin
        unique case (reg_idx)
            fpip_pkg::RegPropGain:   prdata = {16'd0, prop_gain_reg};
            fpip_pkg::RegIntegGain:  prdata = {16'd0, integ_gain_reg};
            fpip_pkg::RegLowerLimit: prdata = {{20{lower_limit_reg[11]}}, lower_limit_reg};
            fpip_pkg::RegUpperLimit: prdata = {20'd0, upper_limit_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    assign cfg.prop_gain   = prop_gain_reg;
    assign cfg.integ_gain  = integ_gain_reg;
    assign cfg.lower_limit = lower_limit_reg;
    assign cfg.upper_limit = upper_limit_reg;

endmodule

/* design/fpip_core.sv */
// Controller datapath: input register, combinational PI update, output register.
module fpip_core (
    input  logic           clk,
    input  logic           rst_n,
    input  fpip_pkg::cfg_t cfg,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [11:0]    in_target,
    input  logic [11:0]    in_meas,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [15:0]    out_drive
);

    logic               in_valid_reg;
    logic               in_valid_next;
    logic [11:0]        in_target_reg;
    logic [11:0]        in_meas_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [15:0]        out_drive_reg;
    logic [15:0]        acc_reg;
    logic [15:0]        acc_next;
    logic [11:0]        prev_reg;
    logic               in_take;
    logic               out_load;

    logic signed [16:0] err_raw;
    logic signed [16:0] err_clamped;
    logic signed [12:0] err_val;
    logic signed [12:0] delta;
    logic signed [16:0] prop_gain_s;
    logic signed [16:0] integ_gain_s;
    logic signed [29:0] p_prod;
    logic signed [29:0] i_prod;
    logic [15:0]        p16;
    logic [15:0]        i16;
    logic [15:0]        sum;
    logic signed [16:0] acc_clamped;
    logic [15:0]        drive_next;

    // Handshake: the input stage moves on whenever the output register is free
    // or being emptied in the same cycle.
    assign out_load  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || out_load;
    assign in_take   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_drive = out_drive_reg;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Clamped error and change in measurement.
    assign err_raw     = $signed({5'd0, in_target_reg}) - $signed({5'd0, in_meas_reg});
    assign err_clamped = fpip_pkg::clamp_lim(err_raw, cfg.lower_limit, cfg.upper_limit);
    assign err_val     = err_clamped[12:0];
    assign delta       = $signed({1'b0, in_meas_reg}) - $signed({1'b0, prev_reg});

    // Proportional and integral products with floor shifts, low 16 bits kept.
    assign prop_gain_s  = $signed({1'b0, cfg.prop_gain});
    assign integ_gain_s = $signed({1'b0, cfg.integ_gain});
    assign p_prod       = prop_gain_s * delta;
    assign i_prod       = integ_gain_s * err_val;
    assign p16          = p_prod[27:12];
    assign i16          = {{2{i_prod[29]}}, i_prod[29:16]};

    // Wrapping accumulator update, clamp, and output offset.
    assign sum         = acc_reg - p16 + i16;
    assign acc_clamped = fpip_pkg::clamp_lim($signed({sum[15], sum}), cfg.lower_limit,
                                             cfg.upper_limit);
    assign acc_next    = acc_clamped[15:0];
    assign drive_next  = {4'd0, cfg.upper_limit} + acc_next;

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            prev_reg      <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (out_load)
            begin
                acc_reg  <= acc_next;
                prev_reg <= in_meas_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_target_reg <= in_target;
            in_meas_reg   <= in_meas;
        end
        if (out_load)
        begin
            out_drive_reg <= drive_next;
        end
    end

    // With ordered limits the accumulator lands inside them after an update.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (cfg.lower_limit <= $signed({1'b0, cfg.upper_limit})))
        |=> (($signed(acc_reg) <= $signed({5'd0, $past(cfg.upper_limit)}))
            && ($signed(acc_reg) >= $signed({{5{$past(cfg.lower_limit[11])}},
                                              $past(cfg.lower_limit)}))))
        else $error("accumulator outside limits after update");

    // The stored measurement follows the item just processed.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (prev_reg == $past(in_meas_reg)))
        else $error("previous measurement not updated");

    // The output word equals upper limit plus the new accumulator.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (out_drive_reg == ({4'd0, $past(cfg.upper_limit)} + acc_reg)))
        else $error("drive word does not match accumulator");

    // An empty output register never blocks the input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled while output register empty");

endmodule

/* design/fixed_point_incremental_pi.sv */
// Top level of the fixed-point incremental PI controller.
// Usage:
//   Each input word on s_axis carries a 12-bit setpoint and a 12-bit
//   measurement. For every input word the controller returns exactly one
//   16-bit drive word on m_axis, in order.
//   Gains and limits are set through the APB-style port at byte addresses
//   0 (proportional gain), 4 (integral gain), 8 (lower limit), 12 (upper
//   limit); write them only while no word is in flight.
//   An accepted input word is held in the input register and its drive word
//   in the output register, from which it shows on m_axis. One word is
//   accepted every cycle while m_axis_tready is high; the rate is set by
//   the accumulator update, whose two multiplies and clamps sit between the input register and the output register.
//   When the receiver stalls, the drive word holds in the output register
//   and one more input word can wait in the input register before
//   s_axis_tready falls.
//   Reset clears the accumulator, the stored measurement and both stages,
//   and loads the default gains and limits.
module fixed_point_incremental_pi (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [11:0] target_value, [23:12] measured_value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] drive_value
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    fpip_pkg::cfg_t cfg;

    // Configuration registers.
    fpip_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Controller datapath.
    fpip_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_target (s_axis_tdata[11:0]),
        .in_meas   (s_axis_tdata[23:12]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_drive (m_axis_tdata)
    );

endmodule
